// ===== src/lbq_pkg.sv =====
`timescale 1ns / 1ps
// Leaky-bucket queue package: sizes, codes, field types and the structs
// passed between the submodules. No dependencies.
package lbq_pkg;

   localparam int BUCKET_DEPTH = 64;
   localparam int MAX_LEAK     = 16;

   localparam int PTR_W      = $clog2(BUCKET_DEPTH);
   localparam int OCC_W      = $clog2(BUCKET_DEPTH + 1);
   localparam int LEAK_W     = $clog2(MAX_LEAK + 1);
   localparam int ID_W       = 16;
   localparam int FILL_W     = 7;
   localparam int BSIZE_W    = 7;
   localparam int LRATE_W    = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(64);
   localparam logic [LRATE_W-1:0] LRATE_RESET = LRATE_W'(1);

   typedef logic [ID_W-1:0]   id_type;
   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [OCC_W-1:0]  occ_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic {
      OP_ARRIVAL = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_DROP   = 2'd1,
      KIND_SENT   = 2'd2,
      KIND_EMPTY  = 2'd3
   } kind_type;

   typedef enum logic {
      REG_FILL_LIMIT = 1'b0,
      REG_LEAK_RATE  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [BSIZE_W-1:0] fill_limit;
      logic [LRATE_W-1:0] leak_rate;
   } cfg_type;

   typedef struct packed {
      logic    wr_en;
      ptr_type wr_addr;
      id_type  wr_data;
      logic    rd_en;
      ptr_type rd_addr;
   } mem_req_type;

endpackage

// ===== src/lbq_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the leaky-bucket queue: valid/ready plus one word.
// Depends on lbq_pkg.
interface lbq_req_if;
   import lbq_pkg::*;

   logic   valid;
   logic   ready;
   op_type operation;
   id_type packet_id;

   modport source (output valid, output operation, output packet_id, input ready);
   modport sink   (input valid, input operation, input packet_id, output ready);
endinterface

// ===== src/lbq_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the leaky-bucket queue: valid/ready plus one word.
// Depends on lbq_pkg.
interface lbq_rsp_if;
   import lbq_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   id_type   packet_id_res;
   fill_type fill;
   logic     last;

   modport source (output valid, output kind, output packet_id_res, output fill,
                   output last, input ready);
   modport sink   (input valid, input kind, input packet_id_res, input fill,
                   input last, output ready);
endinterface

// ===== src/leaky_bucket_packet_queue_core.sv =====
`timescale 1ns / 1ps
// Leaky-bucket packet queue, top level: register block, id store, sequencer.
// Depends on lbq_pkg, lbq_req_if, lbq_rsp_if, lbq_csr, lbq_store, lbq_ctrl.
//
//   channel  direction  handshake            word
//   req_ch   in         valid/ready          operation, packet_id
//   rsp_ch   out        valid/ready          kind, packet_id_res, fill, last
//   csr_*    in/out     APB psel/penable     fill limit @0x0, leak_rate @0x4
//
// An arrival or an empty tick loads its response word in EXEC, and the input
// is ready again back in IDLE: no new request is taken while one is in flight.
// A tick that drains n packets fetches the head id in EXEC, then loads one word
// per cycle in SEND while the response is not stalled; the nth word has last set.
// Reset clears pointers and occupancy at once; no clearing pass.
// A stalled response holds the sequencer in place, nothing is dropped.
module leaky_bucket_packet_queue_core (
   input  logic                            clock,
   input  logic                            reset,
   lbq_req_if.sink                         req_ch,
   lbq_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lbq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lbq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import lbq_pkg::*;

   cfg_type     cfg;
   mem_req_type mem_req;
   id_type      rd_data;

   // configuration registers
   lbq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // FIFO body of the bucket
   lbq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // admit, drop and drain
   lbq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );
endmodule

// ===== src/lbq_csr.sv =====
`timescale 1ns / 1ps
// APB-style register block: fill limit and leak rate.
// Depends on lbq_pkg.
module lbq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lbq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lbq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output lbq_pkg::cfg_type                cfg
);
   import lbq_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type sel;
   logic        wr_hit;

   assign sel        = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         unique case (sel)
            REG_FILL_LIMIT: cfg_in.fill_limit = csr_pwdata[BSIZE_W-1:0];
            REG_LEAK_RATE:  cfg_in.leak_rate  = csr_pwdata[LRATE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_FILL_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.fill_limit);
         REG_LEAK_RATE:  csr_prdata = CSR_DATA_W'(cfg_ff.leak_rate);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_limit <= BSIZE_RESET;
         cfg_ff.leak_rate  <= LRATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== src/lbq_store.sv =====
`timescale 1ns / 1ps
// Packet id storage: one write port, one read port with registered data.
// Depends on lbq_pkg.
module lbq_store (
   input  logic                 clock,
   input  lbq_pkg::mem_req_type mem_req,
   output lbq_pkg::id_type      rd_data
);
   import lbq_pkg::*;

   id_type mem [BUCKET_DEPTH];
   id_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/lbq_ctrl.sv =====
`timescale 1ns / 1ps
// Queue sequencer: pointers, occupancy, drain counter and the response register.
// Depends on lbq_pkg, lbq_req_if, lbq_rsp_if.
module lbq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  lbq_pkg::cfg_type     cfg,
   lbq_req_if.sink              req_ch,
   lbq_rsp_if.source            rsp_ch,
   output lbq_pkg::mem_req_type mem_req,
   input  lbq_pkg::id_type      rd_data
);
   import lbq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   ptr_type               head_ff, head_in, tail_ff, tail_in, head_next, tail_next;
   occ_type               occ_ff, occ_in;
   logic [LEAK_W-1:0]     remain_ff, remain_in, n_count;
   op_type                op_ff, op_in;
   id_type                pid_ff, pid_in;
   logic                  rvalid_ff, rvalid_in;
   kind_type              kind_ff, kind_in;
   id_type                rid_ff, rid_in;
   fill_type              fill_ff, fill_in;
   logic                  last_ff, last_in;
   logic                  slot_free, load, full;
   logic [31:0]           lr;

   assign slot_free = !rvalid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign head_next = (32'(head_ff) == BUCKET_DEPTH - 1) ? '0 : head_ff + 1'b1;
   assign tail_next = (32'(tail_ff) == BUCKET_DEPTH - 1) ? '0 : tail_ff + 1'b1;
   assign full = (32'(occ_ff) >= 32'(cfg.fill_limit)) ||
                 (32'(occ_ff) >= BUCKET_DEPTH);

   // packets to send on this tick: leak rate clamped to [1, MAX_LEAK] and fill
   always_comb begin
      lr = 32'(cfg.leak_rate);
      if (lr == 0) lr = 1;
      if (lr > MAX_LEAK) lr = MAX_LEAK;
      if (lr > 32'(occ_ff)) lr = 32'(occ_ff);
      n_count = LEAK_W'(lr);
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      remain_in = remain_ff;
      op_in     = op_ff;
      pid_in    = pid_ff;
      kind_in   = kind_ff;
      rid_in    = rid_ff;
      fill_in   = fill_ff;
      last_in   = last_ff;
      load      = 1'b0;
      mem_req   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               pid_in   = req_ch.packet_id;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_ARRIVAL) begin
               if (slot_free) begin
                  load     = 1'b1;
                  rid_in   = pid_ff;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
                  if (full) begin
                     kind_in = KIND_DROP;
                     fill_in = FILL_W'(occ_ff);
                  end else begin
                     kind_in         = KIND_ACCEPT;
                     fill_in         = FILL_W'(occ_ff + 1'b1);
                     occ_in          = occ_ff + 1'b1;
                     tail_in         = tail_next;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = tail_ff;
                     mem_req.wr_data = pid_ff;
                  end
               end
            end else if (occ_ff == '0) begin
               if (slot_free) begin
                  load     = 1'b1;
                  kind_in  = KIND_EMPTY;
                  rid_in   = '0;
                  fill_in  = '0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               // prefetch the head word
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = head_ff;
               remain_in       = n_count;
               state_in        = ST_SEND;
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               load      = 1'b1;
               kind_in   = KIND_SENT;
               rid_in    = rd_data;
               fill_in   = FILL_W'(occ_ff - 1'b1);
               last_in   = (remain_ff == LEAK_W'(1));
               occ_in    = occ_ff - 1'b1;
               head_in   = head_next;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == LEAK_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_next;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rvalid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         remain_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         remain_ff <= remain_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pid_ff  <= pid_in;
      kind_ff <= kind_in;
      rid_ff  <= rid_in;
      fill_ff <= fill_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid         = rvalid_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.packet_id_res = rid_ff;
   assign rsp_ch.fill          = fill_ff;
   assign rsp_ch.last          = last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= BUCKET_DEPTH)
      else $error("occupancy above bucket depth");

   a_send_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (remain_ff != '0))
      else $error("drain running with nothing left to send");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty bucket with pointers apart");

   a_send_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && slot_free) |=> (rvalid_ff && kind_ff == KIND_SENT))
      else $error("drain step did not present a sent word");
endmodule

// ===== bench/leaky_bucket_packet_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the leaky-bucket packet queue: directed table, then random
// phases across bucket/leak settings and idle patterns. Depends on lbq_pkg, lbq_req_if,
// lbq_rsp_if and leaky_bucket_packet_queue_core.
module leaky_bucket_packet_queue_core_tb;
   import lbq_pkg::*;

   // Generous bound: ~130 items, up to 16 words each, long random stalls on both sides.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Cycles to let pass once nothing is owed.
   localparam int SETTLE_CYCLES = 4;

   // One response word as the bench sees it.
   typedef struct packed {
      kind_type kind;
      id_type   id;
      fill_type fill;
      logic     last;
   } rsp_word_t;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_t;

   // Directed row: either a request word (optionally with its response typed in)
   // or a register write.
   typedef struct packed {
      row_kind_t          row;
      op_type             op;
      id_type             id;
      logic               pinned;
      rsp_word_t          want;
      csr_reg_type        target;
      logic [BSIZE_W-1:0] setting;
   } plan_row_t;

   typedef struct {
      int size;
      int leak;
      int send_idle;
      int stall;
      int items;
      int arrive_pct;
   } phase_t;

   logic clock;
   logic reset;

   lbq_req_if req_ch ();
   lbq_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   leaky_bucket_packet_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bucket shadow: held ids in FIFO order plus the two register copies.
   id_type             bucket_ids [$];
   logic [BSIZE_W-1:0] size_reg = BSIZE_RESET;
   logic [LRATE_W-1:0] leak_reg = LRATE_RESET;

   // Response words still owed by the block, oldest first.
   rsp_word_t owed_words [$];

   // Typed-in response for the word currently on the request channel.
   logic      pin_on;
   rsp_word_t pin_word;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          errors        = 0;
   int unsigned cycles        = 0;

   // Directed stimulus. Rows with pinned = 1 carry the response read straight off
   // the bucket rules; the rest are checked against the shadow.
   plan_row_t directed_plan [22] = '{
      // default setup (size 64, leak 1): tick on an empty bucket
      '{ROW_ITEM, OP_TICK,    16'h0000, 1, '{KIND_EMPTY,  16'h0000, 0, 1}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_ARRIVAL, 16'h0000, 1, '{KIND_ACCEPT, 16'h0000, 1, 1}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_ARRIVAL, 16'hFFFF, 1, '{KIND_ACCEPT, 16'hFFFF, 2, 1}, REG_FILL_LIMIT, 0},
      // tick carries an id that must be ignored
      '{ROW_ITEM, OP_TICK,    16'hFFFF, 1, '{KIND_SENT,   16'h0000, 1, 1}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_ARRIVAL, 16'h8001, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      // bucket size zero drops everything
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_ARRIVAL, 16'h1234, 1, '{KIND_DROP,   16'h1234, 2, 1}, REG_FILL_LIMIT, 0},
      // drop exactly at the size
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 2},
      '{ROW_ITEM, OP_ARRIVAL, 16'h5555, 1, '{KIND_DROP,   16'h5555, 2, 1}, REG_FILL_LIMIT, 0},
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 3},
      '{ROW_ITEM, OP_ARRIVAL, 16'hAAAA, 1, '{KIND_ACCEPT, 16'hAAAA, 3, 1}, REG_FILL_LIMIT, 0},
      // leak rate zero behaves as one
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_LEAK_RATE,  0},
      '{ROW_ITEM, OP_TICK,    16'h0000, 1, '{KIND_SENT,   16'hFFFF, 2, 1}, REG_FILL_LIMIT, 0},
      // leak rate above the limit, drain limited by occupancy
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_LEAK_RATE, 31},
      '{ROW_ITEM, OP_ARRIVAL, 16'h7FFE, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_TICK,    16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_TICK,    16'h0000, 1, '{KIND_EMPTY,  16'h0000, 0, 1}, REG_FILL_LIMIT, 0},
      // size above the depth, leak at its limit
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 127},
      '{ROW_CSR,  OP_ARRIVAL, 16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_LEAK_RATE, 16},
      '{ROW_ITEM, OP_ARRIVAL, 16'h00FF, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_ARRIVAL, 16'hFF00, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0},
      '{ROW_ITEM, OP_TICK,    16'h0000, 0, '{KIND_ACCEPT, 16'h0000, 0, 0}, REG_FILL_LIMIT, 0}
   };

   // Random phases: size, leak, sender idle %, receiver stall %, items, arrival %.
   // The second phase is all arrivals so the bucket reaches full depth and drops.
   phase_t phases [5] = '{
      '{64,   1,  0,  0,  6,  60},
      '{127,  1, 66,  0, 66, 100},
      '{64,  16,  0, 66, 14,  25},
      '{5,    3, 31, 31, 22,  60},
      '{1,   31,  0,  0,  6,  50}
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Work out the words one request produces and advance the shadow bucket.
   function automatic void bucket_step(input op_type op, input id_type pid,
                                       output rsp_word_t words [$]);
      int     cap;
      int     n;
      id_type head_id;
      words = {};
      cap = (int'(size_reg) > BUCKET_DEPTH) ? BUCKET_DEPTH : int'(size_reg);
      if (op == OP_ARRIVAL) begin
         if (bucket_ids.size() >= cap) begin
            words.push_back('{KIND_DROP, pid, fill_type'(bucket_ids.size()), 1'b1});
         end else begin
            bucket_ids.push_back(pid);
            words.push_back('{KIND_ACCEPT, pid, fill_type'(bucket_ids.size()), 1'b1});
         end
      end else if (bucket_ids.size() == 0) begin
         words.push_back('{KIND_EMPTY, id_type'(0), fill_type'(0), 1'b1});
      end else begin
         // leak zero acts as one; clamp to the per-tick limit and to what is held
         n = (leak_reg == '0) ? 1 : int'(leak_reg);
         if (n > MAX_LEAK) n = MAX_LEAK;
         if (n > bucket_ids.size()) n = bucket_ids.size();
         for (int k = 0; k < n; k++) begin
            head_id = bucket_ids.pop_front();
            words.push_back('{KIND_SENT, head_id, fill_type'(bucket_ids.size()), k == n - 1});
         end
      end
   endfunction

   // Offer one request word; return after the edge that accepts it, valid still high.
   task automatic send_word(input op_type op, input id_type pid, input logic pinned,
                            input rsp_word_t want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      pin_on   = pinned;
      pin_word = want;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.packet_id <= pid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every owed word has come back, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (owed_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup cycle, access cycle, done at the edge with pready high.
   task automatic csr_write(input csr_reg_type target, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({target, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (target == REG_FILL_LIMIT)
         size_reg = value[BSIZE_W-1:0];
      else
         leak_reg = value[LRATE_W-1:0];
   endtask

   // Receiver: stall at the phase's rate, change ready only at the falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words still owed", $time, owed_words.size());
         $display("leaky_bucket_packet_queue_core_tb: done, errors");
         $finish;
      end
   end

   // Scoreboard: check each accepted response word against the oldest owed word, then
   // queue up what a request accepted at this edge will produce.
   always @(posedge clock) begin : scoreboard
      rsp_word_t got;
      rsp_word_t want;
      rsp_word_t made [$];
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.packet_id_res, rsp_ch.fill, rsp_ch.last};
            if (owed_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none,", $time,
                        " actual kind=%0d id=%h fill=%0d last=%0b",
                        got.kind, got.id, got.fill, got.last);
            end else begin
               want = owed_words.pop_front();
               if (got.kind !== want.kind || got.id !== want.id ||
                   got.fill !== want.fill || got.last !== want.last) begin
                  errors++;
                  $display("%0t: mismatch, expected kind=%0d id=%h fill=%0d last=%0b,",
                           $time, want.kind, want.id, want.fill, want.last,
                           " actual kind=%0d id=%h fill=%0d last=%0b",
                           got.kind, got.id, got.fill, got.last);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            bucket_step(req_ch.operation, req_ch.packet_id, made);
            // a typed-in row replaces the shadow's single word, the shadow still advances
            if (pin_on)
               owed_words.push_back(pin_word);
            else
               foreach (made[i]) owed_words.push_back(made[i]);
         end
      end
   end

   initial begin
      op_type op;
      id_type pid;
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_ARRIVAL;
      req_ch.packet_id = '0;
      rsp_ch.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      pin_on           = 1'b0;
      pin_word         = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table with no idling on either side.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].row == ROW_CSR)
            csr_write(directed_plan[i].target, CSR_DATA_W'(directed_plan[i].setting));
         else
            send_word(directed_plan[i].op, directed_plan[i].id, directed_plan[i].pinned,
                      directed_plan[i].want);
      end

      // Random phases; the bucket contents carry over from one phase to the next.
      foreach (phases[p]) begin
         csr_write(REG_FILL_LIMIT, CSR_DATA_W'(phases[p].size));
         csr_write(REG_LEAK_RATE, CSR_DATA_W'(phases[p].leak));
         send_idle_pct = phases[p].send_idle;
         stall_pct     = phases[p].stall;
         for (int k = 0; k < phases[p].items; k++) begin
            // pause the sender midway until every owed word has come back
            if (k == phases[p].items / 2) wait_drained();
            op = ($urandom_range(0, 99) < phases[p].arrive_pct) ? OP_ARRIVAL : OP_TICK;
            case ($urandom_range(0, 15))
               0:       pid = 16'h0000;
               1:       pid = 16'hFFFF;
               default: pid = id_type'($urandom);
            endcase
            send_word(op, pid, 1'b0, '0);
         end
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      wait_drained();
      if (errors == 0 && owed_words.size() == 0)
         $display("leaky_bucket_packet_queue_core_tb: done, clean");
      else
         $display("leaky_bucket_packet_queue_core_tb: done, errors");
      $finish;
   end

endmodule
